>>> src/rv32_pkg.sv
// ----------------------------------------------------------------------------
// rv32_pkg: shared types and constants
// Opcodes, func/status codes, ALU op codes and ALU request/response structs.
// ----------------------------------------------------------------------------
package rv32_pkg;

    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_SYSTEM = 7'h73;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

    localparam logic [1:0] FUNC_EXEC  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ILLEGAL  = 3'd1;
    localparam logic [2:0] ST_EXIT     = 3'd2;
    localparam logic [2:0] ST_PINT     = 3'd3;
    localparam logic [2:0] ST_PCHAR    = 3'd4;
    localparam logic [2:0] ST_PSTR     = 3'd5;
    localparam logic [2:0] ST_BADECALL = 3'd6;
    localparam logic [2:0] ST_HALTED   = 3'd7;

    typedef enum logic [3:0] {
        ALU_ADD  = 4'd0,
        ALU_SUB  = 4'd1,
        ALU_SLL  = 4'd2,
        ALU_SLT  = 4'd3,
        ALU_SLTU = 4'd4,
        ALU_XOR  = 4'd5,
        ALU_SRL  = 4'd6,
        ALU_SRA  = 4'd7,
        ALU_OR   = 4'd8,
        ALU_AND  = 4'd9,
        ALU_MUL  = 4'd10,
        ALU_MULH = 4'd11,
        ALU_DIV  = 4'd12,
        ALU_REM  = 4'd13
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
        logic [31:0] a;
        logic [31:0] b;
    } alu_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } alu_rsp_t;

endpackage

>>> src/rv32_ram.sv
// ----------------------------------------------------------------------------
// rv32_ram: generic single-port RAM
// One access per cycle, a write when we is set; registered read-first data.
// ----------------------------------------------------------------------------
module rv32_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> src/rv32_alu.sv
// ----------------------------------------------------------------------------
// rv32_alu: shared arithmetic unit
// Combinational add, compare, logic and shift; registered mul; bit-serial div.
// ----------------------------------------------------------------------------
module rv32_alu
    import rv32_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    typedef enum logic [2:0] {
        A_IDLE = 3'b001,
        A_MUL  = 3'b010,
        A_DIV  = 3'b100
    } alu_state_t;

    alu_state_t  state_reg, state_next;
    alu_op_t     op_reg;
    logic [63:0] prod_reg;
    logic [31:0] quot_reg, rem_reg, dvsr_reg, a_reg, b_reg;
    logic [5:0]  cnt_reg;
    logic        qneg_reg, rneg_reg;
    logic [32:0] trial;
    logic [31:0] shifted_rem;
    logic [31:0] mag_a, mag_b;
    logic [31:0] simple;
    logic [31:0] qres, rres;

    assign mag_a = req.a[31] ? (32'd0 - req.a) : req.a;
    assign mag_b = req.b[31] ? (32'd0 - req.b) : req.b;

    always_comb begin
        case (req.op)
            ALU_ADD:  simple = req.a + req.b;
            ALU_SUB:  simple = req.a - req.b;
            ALU_SLL:  simple = req.a << req.b[4:0];
            ALU_SLT:  simple = {31'd0, $signed(req.a) < $signed(req.b)};
            ALU_SLTU: simple = {31'd0, req.a < req.b};
            ALU_XOR:  simple = req.a ^ req.b;
            ALU_SRL:  simple = req.a >> req.b[4:0];
            ALU_SRA:  simple = 32'($signed(req.a) >>> req.b[4:0]);
            ALU_OR:   simple = req.a | req.b;
            ALU_AND:  simple = req.a & req.b;
            default:  simple = 32'd0;
        endcase
    end

    assign shifted_rem = {rem_reg[30:0], quot_reg[31]};
    assign trial       = {1'b0, shifted_rem} - {1'b0, dvsr_reg};

    assign qres = qneg_reg ? (32'd0 - quot_reg) : quot_reg;
    assign rres = rneg_reg ? (32'd0 - rem_reg) : rem_reg;

    always_comb begin
        state_next = state_reg;
        rsp.done   = 1'b0;
        rsp.result = simple;
        case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    if (req.op == ALU_MUL || req.op == ALU_MULH) begin
                        state_next = A_MUL;
                    end else if (req.op == ALU_DIV || req.op == ALU_REM) begin
                        state_next = A_DIV;
                    end else begin
                        rsp.done = 1'b1;
                    end
                end
            end
            A_MUL: begin
                rsp.done   = 1'b1;
                rsp.result = (op_reg == ALU_MUL) ? prod_reg[31:0] : prod_reg[63:32];
                state_next = A_IDLE;
            end
            A_DIV: begin
                if (cnt_reg == 6'd32) begin
                    rsp.done   = 1'b1;
                    state_next = A_IDLE;
                    if (b_reg == 32'd0) begin
                        rsp.result = (op_reg == ALU_DIV) ? 32'hFFFF_FFFF : a_reg;
                    end else begin
                        rsp.result = (op_reg == ALU_DIV) ? qres : rres;
                    end
                end
            end
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == A_IDLE && req.start) begin
            op_reg   <= req.op;
            a_reg    <= req.a;
            b_reg    <= req.b;
            prod_reg <= 64'($signed({req.a[31] & (req.op == ALU_MULH), req.a})
                          * $signed({req.b[31] & (req.op == ALU_MULH), req.b}));
            quot_reg <= mag_a;
            rem_reg  <= 32'd0;
            dvsr_reg <= mag_b;
            cnt_reg  <= 6'd0;
            qneg_reg <= req.a[31] ^ req.b[31];
            rneg_reg <= req.a[31];
        end else if (state_reg == A_DIV && cnt_reg != 6'd32) begin
            // restoring step: one quotient bit per cycle
            cnt_reg <= cnt_reg + 6'd1;
            if (!trial[32]) begin
                rem_reg  <= trial[31:0];
                quot_reg <= {quot_reg[30:0], 1'b1};
            end else begin
                rem_reg  <= shifted_rem;
                quot_reg <= {quot_reg[30:0], 1'b0};
            end
        end
    end

endmodule

>>> src/rv32im_subset_execute.sv
// ----------------------------------------------------------------------------
// rv32im_subset_execute: RV32IM subset instruction executor
// Sequencer with register file, program counter, byte memory and shared ALU.
// ----------------------------------------------------------------------------
// Input items arrive on the s_axis channel (func in tuser, instruction,
// byte address and mem_data in tdata); one result per item leaves on m_axis
// (status, pc and value in tdata). func 0 executes an instruction, func 1
// writes a little-endian word to memory, func 2 reads one back.
// An item is taken only while the block is idle. Each item passes the
// register-read and decode states; ALU items then wait in the ALU state,
// mul and mulh on the registered product, div and rem on the bit-serial
// divider, which sets the worst case. lui, auipc, jal, branch, ecall,
// illegal and halted items go from decode to the done state. Loads, stores
// and word-wide memory items step through the single-port byte RAM, which
// sets their time: a write step, or a read and a wait state, per byte. The
// block returns to idle after the result transfer and takes the next item.
// The result is held in an output register; while the receiver stalls the
// result stays and no new item is accepted.
// Reset clears the register file, pc and halted flag; memory contents stay
// undefined until written, and no clearing pass is run.
// ----------------------------------------------------------------------------
module rv32im_subset_execute
    import rv32_pkg::*;
#(
    parameter int MEM_BYTES = 65536
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // instruction[31:0], byte address[47:32], mem_data[79:48]
    input  logic [79:0]  s_axis_tdata,
    // func[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], pc[34:3], value[66:35], zero fill to 72 bits
    output logic [71:0]  m_axis_tdata
);

    localparam int AW = $clog2(MEM_BYTES);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DEC   = 8'b0000_0010,
        S_ALU   = 8'b0000_0100,
        S_MEM   = 8'b0000_1000,
        S_MWAIT = 8'b0001_0000,
        S_DONE  = 8'b0010_0000,
        S_OUT   = 8'b0100_0000,
        S_RDRF  = 8'b1000_0000
    } state_t;

    state_t      state_reg;
    state_t      dec_state;
    logic [31:0] regs_reg [32];
    logic [31:0] pc_reg;
    logic        halted_reg;
    logic [1:0]  func_reg;
    logic [31:0] ins_reg;
    logic [31:0] maddr_reg;
    logic [31:0] mdata_reg;
    logic [31:0] a_reg, b_reg;
    logic [2:0]  nbytes_reg;
    logic [2:0]  bidx_reg;
    logic        mwrite_reg;
    logic [31:0] acc_reg;
    logic [2:0]  status_reg;
    logic [31:0] value_reg;
    logic        out_valid_reg;

    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;

    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;
    logic        alu_ok;
    alu_op_t     alu_op;

    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]  ram_wdata, ram_rdata;
    logic [31:0] byte_addr;

    assign opc   = ins_reg[6:0];
    assign rd    = ins_reg[11:7];
    assign f3    = ins_reg[14:12];
    assign f7    = ins_reg[31:25];
    assign imm_i = {{20{ins_reg[31]}}, ins_reg[31:20]};
    assign imm_s = {{20{ins_reg[31]}}, ins_reg[31:25], ins_reg[11:7]};
    assign imm_b = {{20{ins_reg[31]}}, ins_reg[7], ins_reg[30:25], ins_reg[11:8], 1'b0};
    assign imm_j = {{12{ins_reg[31]}}, ins_reg[19:12], ins_reg[20], ins_reg[30:21], 1'b0};
    assign imm_u = {ins_reg[31:12], 12'd0};

    // decode R and I forms to an ALU operation
    always_comb begin
        alu_ok = 1'b1;
        alu_op = ALU_ADD;
        if (opc == OP_REG) begin
            case ({f3, f7})
                {3'd0, 7'h00}:    alu_op = ALU_ADD;
                {3'd0, F7_MULDIV}: alu_op = ALU_MUL;
                {3'd0, F7_ALT}:   alu_op = ALU_SUB;
                {3'd1, 7'h00}:    alu_op = ALU_SLL;
                {3'd1, F7_MULDIV}: alu_op = ALU_MULH;
                {3'd2, 7'h00}:    alu_op = ALU_SLT;
                {3'd4, 7'h00}:    alu_op = ALU_XOR;
                {3'd4, F7_MULDIV}: alu_op = ALU_DIV;
                {3'd5, 7'h00}:    alu_op = ALU_SRL;
                {3'd5, F7_ALT}:   alu_op = ALU_SRA;
                {3'd6, 7'h00}:    alu_op = ALU_OR;
                {3'd6, F7_MULDIV}: alu_op = ALU_REM;
                {3'd7, 7'h00}:    alu_op = ALU_AND;
                default:          alu_ok = 1'b0;
            endcase
        end else begin
            case (f3)
                3'd0: alu_op = ALU_ADD;
                3'd1: begin
                    alu_op = ALU_SLL;
                    alu_ok = (f7 == 7'h00);
                end
                3'd2: alu_op = ALU_SLT;
                3'd3: alu_op = ALU_SLTU;
                3'd4: alu_op = ALU_XOR;
                3'd5: begin
                    alu_op = (f7 == F7_ALT) ? ALU_SRA : ALU_SRL;
                    alu_ok = (f7 == 7'h00) || (f7 == F7_ALT);
                end
                3'd6: alu_op = ALU_OR;
                default: alu_op = ALU_AND;
            endcase
        end
    end

    // state that follows decode
    always_comb begin
        dec_state = S_DONE;
        if (func_reg == FUNC_WRITE || func_reg == FUNC_READ) begin
            dec_state = S_MEM;
        end else if (func_reg == FUNC_EXEC && !halted_reg) begin
            case (opc)
                OP_REG, OP_IMM:    dec_state = alu_ok ? S_ALU : S_DONE;
                OP_LOAD, OP_STORE: dec_state = (f3 <= 3'd2) ? S_MEM : S_DONE;
                default:           dec_state = S_DONE;
            endcase
        end
    end

    always_comb begin
        alu_req.start = (state_reg == S_ALU);
        alu_req.op    = alu_op;
        alu_req.a     = a_reg;
        alu_req.b     = (opc == OP_REG) ? b_reg : imm_i;
    end

    rv32_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

    assign byte_addr = maddr_reg + {29'd0, bidx_reg};
    assign ram_addr  = byte_addr[AW-1:0];
    assign ram_we    = (state_reg == S_MEM) && mwrite_reg;
    assign ram_wdata = mdata_reg[8*bidx_reg[1:0] +: 8];

    rv32_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, value_reg, pc_reg, status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pc_reg        <= 32'd0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 32; i++) begin
                regs_reg[i] <= 32'd0;
            end
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        func_reg   <= s_axis_tuser;
                        ins_reg    <= s_axis_tdata[31:0];
                        maddr_reg  <= {16'd0, s_axis_tdata[47:32]};
                        mdata_reg  <= s_axis_tdata[79:48];
                        status_reg <= ST_OK;
                        value_reg  <= 32'd0;
                        state_reg  <= S_RDRF;
                    end
                end
                S_RDRF: begin
                    a_reg     <= regs_reg[ins_reg[19:15]];
                    b_reg     <= regs_reg[ins_reg[24:20]];
                    state_reg <= S_DEC;
                end
                S_DEC: begin
                    state_reg <= dec_state;
                    bidx_reg  <= 3'd0;
                    acc_reg   <= 32'd0;
                    if (func_reg == FUNC_WRITE) begin
                        nbytes_reg <= 3'd4;
                        mwrite_reg <= 1'b1;
                    end else if (func_reg == FUNC_READ) begin
                        nbytes_reg <= 3'd4;
                        mwrite_reg <= 1'b0;
                    end else if (func_reg == FUNC_EXEC) begin
                        if (halted_reg) begin
                            status_reg <= ST_HALTED;
                        end else begin
                            case (opc)
                                OP_REG, OP_IMM: begin
                                    if (!alu_ok) begin
                                        status_reg <= ST_ILLEGAL;
                                        halted_reg <= 1'b1;
                                    end
                                end
                                OP_LOAD: begin
                                    if (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2) begin
                                        maddr_reg  <= a_reg + imm_i;
                                        nbytes_reg <= 3'd1 << f3[1:0];
                                        mwrite_reg <= 1'b0;
                                    end else begin
                                        status_reg <= ST_ILLEGAL;
                                        halted_reg <= 1'b1;
                                    end
                                end
                                OP_STORE: begin
                                    if (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2) begin
                                        maddr_reg  <= a_reg + imm_s;
                                        mdata_reg  <= b_reg;
                                        nbytes_reg <= 3'd1 << f3[1:0];
                                        mwrite_reg <= 1'b1;
                                    end else begin
                                        status_reg <= ST_ILLEGAL;
                                        halted_reg <= 1'b1;
                                    end
                                end
                                OP_BRANCH: begin
                                    if (f3 == 3'd0 || f3 == 3'd1) begin
                                        if ((f3 == 3'd0) == (a_reg == b_reg)) begin
                                            pc_reg <= pc_reg + imm_b;
                                        end else begin
                                            pc_reg <= pc_reg + 32'd4;
                                        end
                                    end else begin
                                        status_reg <= ST_ILLEGAL;
                                        halted_reg <= 1'b1;
                                    end
                                end
                                OP_JAL: begin
                                    if (rd != 5'd0) begin
                                        regs_reg[rd] <= pc_reg + 32'd4;
                                    end
                                    pc_reg <= pc_reg + imm_j;
                                end
                                OP_LUI: begin
                                    if (rd != 5'd0) begin
                                        regs_reg[rd] <= imm_u;
                                    end
                                    pc_reg <= pc_reg + 32'd4;
                                end
                                OP_AUIPC: begin
                                    if (rd != 5'd0) begin
                                        regs_reg[rd] <= pc_reg + imm_u;
                                    end
                                    pc_reg <= pc_reg + 32'd4;
                                end
                                OP_SYSTEM: begin
                                    if (ins_reg != ECALL_WORD) begin
                                        status_reg <= ST_ILLEGAL;
                                        halted_reg <= 1'b1;
                                    end else if (regs_reg[10] == 32'd1) begin
                                        status_reg <= ST_PINT;
                                        value_reg  <= regs_reg[11];
                                        pc_reg     <= pc_reg + 32'd4;
                                    end else if (regs_reg[10] == 32'd4) begin
                                        status_reg <= ST_PSTR;
                                        value_reg  <= regs_reg[11];
                                        pc_reg     <= pc_reg + 32'd4;
                                    end else if (regs_reg[10] == 32'd11) begin
                                        status_reg <= ST_PCHAR;
                                        value_reg  <= regs_reg[11];
                                        pc_reg     <= pc_reg + 32'd4;
                                    end else if (regs_reg[10] == 32'd10) begin
                                        status_reg <= ST_EXIT;
                                        halted_reg <= 1'b1;
                                    end else begin
                                        status_reg <= ST_BADECALL;
                                        value_reg  <= regs_reg[10];
                                        halted_reg <= 1'b1;
                                    end
                                end
                                default: begin
                                    status_reg <= ST_ILLEGAL;
                                    halted_reg <= 1'b1;
                                end
                            endcase
                        end
                    end
                end
                S_ALU: begin
                    if (alu_rsp.done) begin
                        if (rd != 5'd0) begin
                            regs_reg[rd] <= alu_rsp.result;
                        end
                        pc_reg    <= pc_reg + 32'd4;
                        state_reg <= S_DONE;
                    end
                end
                S_MEM: begin
                    // writes take one byte per cycle; reads collect each byte in the wait state
                    if (mwrite_reg) begin
                        bidx_reg <= bidx_reg + 3'd1;
                        if (bidx_reg + 3'd1 == nbytes_reg) begin
                            state_reg <= S_DONE;
                            if (func_reg == FUNC_EXEC) begin
                                pc_reg <= pc_reg + 32'd4;
                            end
                        end
                    end else begin
                        state_reg <= S_MWAIT;
                    end
                end
                S_MWAIT: begin
                    acc_reg[8*bidx_reg[1:0] +: 8] <= ram_rdata;
                    bidx_reg  <= bidx_reg + 3'd1;
                    if (bidx_reg + 3'd1 == nbytes_reg) begin
                        state_reg <= S_DONE;
                        if (func_reg == FUNC_READ) begin
                            value_reg <= {ram_rdata, acc_reg[23:0]};
                        end else begin
                            pc_reg <= pc_reg + 32'd4;
                            if (rd != 5'd0) begin
                                case (nbytes_reg)
                                    3'd1: regs_reg[rd] <= {{24{ram_rdata[7]}}, ram_rdata};
                                    3'd2: regs_reg[rd] <= {{16{ram_rdata[7]}}, ram_rdata,
                                                           acc_reg[7:0]};
                                    default: regs_reg[rd] <= {ram_rdata, acc_reg[23:0]};
                                endcase
                            end
                        end
                    end else begin
                        state_reg <= S_MEM;
                    end
                end
                S_DONE: begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> tb/sv/rv32im_subset_execute_tb.sv
// ----------------------------------------------------------------------------
// rv32im_subset_execute_tb: self-checking bench for the RV32IM subset executor
// Drives instruction, memory-write, memory-read and unused-func transfers
// with random gaps and stalls, predicts status, pc and value of each accepted
// transfer from a private architectural model and compares results in order.
// ----------------------------------------------------------------------------
module rv32im_subset_execute_tb;
    import rv32_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MEM_SIZE       = 65536;
    localparam logic [6:0]  F7_BASE        = 7'h00;
    localparam logic [2:0]  F3_ADD         = 3'd0;
    localparam logic [2:0]  F3_SLL         = 3'd1;
    localparam logic [2:0]  F3_SLT         = 3'd2;
    localparam logic [2:0]  F3_SLTU        = 3'd3;
    localparam logic [2:0]  F3_XOR         = 3'd4;
    localparam logic [2:0]  F3_SR          = 3'd5;
    localparam logic [2:0]  F3_OR          = 3'd6;
    localparam logic [2:0]  F3_AND         = 3'd7;
    localparam logic [2:0]  F3_MUL         = 3'd0;
    localparam logic [2:0]  F3_MULH        = 3'd1;
    localparam logic [2:0]  F3_DIV         = 3'd4;
    localparam logic [2:0]  F3_REM         = 3'd6;
    localparam logic [2:0]  F3_BYTE        = 3'd0;
    localparam logic [2:0]  F3_HALF        = 3'd1;
    localparam logic [2:0]  F3_WORD        = 3'd2;
    localparam logic [2:0]  F3_BEQ         = 3'd0;
    localparam logic [2:0]  F3_BNE         = 3'd1;
    localparam logic [31:0] SYS_PRINT_INT  = 32'd1;
    localparam logic [31:0] SYS_PRINT_STR  = 32'd4;
    localparam logic [31:0] SYS_EXIT       = 32'd10;
    localparam logic [31:0] SYS_PRINT_CHAR = 32'd11;
    localparam logic [1:0]  FUNC_NONE      = 2'd3;
    localparam logic [6:0]  OP_UNUSED      = 7'h7F;
    localparam logic [4:0]  REG_ZERO       = 5'd0;
    localparam logic [4:0]  REG_A0         = 5'd10;
    localparam logic [4:0]  REG_A1         = 5'd11;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] pc;
        logic [31:0] value;
    } exec_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;

    // architectural copy of the core
    logic [31:0] gpr [32];
    logic [31:0] arch_pc;
    logic        arch_halted;
    logic [7:0]  dmem [int];
    logic [15:0] word_addrs [$];

    exec_result_t pending_results [$];
    int errors;
    int items_sent;
    int results_seen;
    int hold_req;
    bit calm;
    string halt_kind;

    rv32im_subset_execute dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // ---------------- architectural model ----------------
    function automatic void mem_put(logic [31:0] addr, int n, logic [31:0] v);
        for (int i = 0; i < n; i++)
            dmem[(addr + i) % MEM_SIZE] = v[8*i +: 8];
        if (n == 4)
            word_addrs.push_back(addr[15:0]);
    endfunction

    function automatic logic [31:0] mem_get(logic [31:0] addr, int n);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < n; i++)
            r[8*i +: 8] = dmem[(addr + i) % MEM_SIZE];
        return r;
    endfunction

    function automatic bit mem_known(logic [31:0] addr, int n);
        for (int i = 0; i < n; i++)
            if (!dmem.exists((addr + i) % MEM_SIZE))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [2:0] run_insn(logic [31:0] ins, output logic [31:0] val);
        logic [6:0]  op;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] a, b, imm, res, addr, off, next_pc;
        logic [4:0]  sh;
        longint      prod;
        bit          wr, bad;
        logic [2:0]  st;
        op = ins[6:0];
        rd = ins[11:7];
        f3 = ins[14:12];
        f7 = ins[31:25];
        a = gpr[ins[19:15]];
        b = gpr[ins[24:20]];
        imm = {{20{ins[31]}}, ins[31:20]};
        sh = ins[24:20];
        res = '0;
        wr = 1'b0;
        bad = 1'b0;
        st = ST_OK;
        val = '0;
        next_pc = arch_pc + 32'd4;
        case (op)
            OP_REG: begin
                wr = 1'b1;
                if (f7 == F7_MULDIV) begin
                    case (f3)
                        F3_MUL: res = a * b;
                        F3_MULH: begin
                            prod = longint'($signed(a)) * longint'($signed(b));
                            res = prod[63:32];
                        end
                        F3_DIV: begin
                            if (b == 0) res = '1;
                            else if (a == 32'h8000_0000 && b == '1) res = a;
                            else res = $signed(a) / $signed(b);
                        end
                        F3_REM: begin
                            if (b == 0) res = a;
                            else if (a == 32'h8000_0000 && b == '1) res = '0;
                            else res = $signed(a) % $signed(b);
                        end
                        default: bad = 1'b1;
                    endcase
                end else if (f7 == F7_ALT) begin
                    if (f3 == F3_ADD) res = a - b;
                    else if (f3 == F3_SR) res = $signed(a) >>> b[4:0];
                    else bad = 1'b1;
                end else if (f7 == F7_BASE) begin
                    case (f3)
                        F3_ADD:  res = a + b;
                        F3_SLL:  res = a << b[4:0];
                        F3_SLT:  res = {31'd0, $signed(a) < $signed(b)};
                        F3_XOR:  res = a ^ b;
                        F3_SR:   res = a >> b[4:0];
                        F3_OR:   res = a | b;
                        F3_AND:  res = a & b;
                        default: bad = 1'b1;
                    endcase
                end else begin
                    bad = 1'b1;
                end
            end
            OP_IMM: begin
                wr = 1'b1;
                case (f3)
                    F3_ADD:  res = a + imm;
                    F3_SLL: begin
                        if (f7 == F7_BASE) res = a << sh;
                        else bad = 1'b1;
                    end
                    F3_SLT:  res = {31'd0, $signed(a) < $signed(imm)};
                    F3_SLTU: res = {31'd0, a < imm};
                    F3_XOR:  res = a ^ imm;
                    F3_SR: begin
                        if (f7 == F7_BASE) res = a >> sh;
                        else if (f7 == F7_ALT) res = $signed(a) >>> sh;
                        else bad = 1'b1;
                    end
                    F3_OR:   res = a | imm;
                    default: res = a & imm;
                endcase
            end
            OP_LOAD: begin
                wr = 1'b1;
                addr = a + imm;
                case (f3)
                    F3_BYTE: begin
                        res = mem_get(addr, 1);
                        res = {{24{res[7]}}, res[7:0]};
                    end
                    F3_HALF: begin
                        res = mem_get(addr, 2);
                        res = {{16{res[15]}}, res[15:0]};
                    end
                    F3_WORD: res = mem_get(addr, 4);
                    default: bad = 1'b1;
                endcase
            end
            OP_STORE: begin
                if (f3 > F3_WORD) begin
                    bad = 1'b1;
                end else begin
                    addr = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
                    mem_put(addr, 1 << f3, b);
                end
            end
            OP_BRANCH: begin
                if (f3 > F3_BNE) begin
                    bad = 1'b1;
                end else begin
                    off = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
                    if ((f3 == F3_BEQ) == (a == b))
                        next_pc = arch_pc + off;
                end
            end
            OP_JAL: begin
                off = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
                wr = 1'b1;
                res = arch_pc + 32'd4;
                next_pc = arch_pc + off;
            end
            OP_LUI: begin
                wr = 1'b1;
                res = {ins[31:12], 12'd0};
            end
            OP_AUIPC: begin
                wr = 1'b1;
                res = arch_pc + {ins[31:12], 12'd0};
            end
            OP_SYSTEM: begin
                if (ins != ECALL_WORD) begin
                    bad = 1'b1;
                end else begin
                    case (gpr[REG_A0])
                        SYS_PRINT_INT:  begin st = ST_PINT;  val = gpr[REG_A1]; end
                        SYS_PRINT_STR:  begin st = ST_PSTR;  val = gpr[REG_A1]; end
                        SYS_PRINT_CHAR: begin st = ST_PCHAR; val = gpr[REG_A1]; end
                        SYS_EXIT: begin
                            st = ST_EXIT;
                            arch_halted = 1'b1;
                            next_pc = arch_pc;
                        end
                        default: begin
                            st = ST_BADECALL;
                            val = gpr[REG_A0];
                            arch_halted = 1'b1;
                            next_pc = arch_pc;
                        end
                    endcase
                end
            end
            default: bad = 1'b1;
        endcase
        if (bad) begin
            arch_halted = 1'b1;
            st = ST_ILLEGAL;
            val = '0;
            next_pc = arch_pc;
            wr = 1'b0;
        end
        if (wr && rd != REG_ZERO)
            gpr[rd] = res;
        arch_pc = next_pc;
        return st;
    endfunction

    function automatic exec_result_t predict_item(logic [1:0] fn, logic [31:0] ins,
                                                  logic [15:0] addr, logic [31:0] data);
        exec_result_t r;
        logic [31:0] v;
        r = '0;
        case (fn)
            FUNC_EXEC: begin
                if (arch_halted) begin
                    r.status = ST_HALTED;
                end else begin
                    r.status = run_insn(ins, v);
                    r.value = v;
                end
            end
            FUNC_WRITE: mem_put({16'd0, addr}, 4, data);
            FUNC_READ:  r.value = mem_get({16'd0, addr}, 4);
            default: ;
        endcase
        gpr[REG_ZERO] = '0;
        r.pc = arch_pc;
        return r;
    endfunction

    // ---------------- encoders ----------------
    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [2:0] f3, logic [4:0] rd,
                                          logic [4:0] rs1, logic [4:0] rs2);
        return {f7, rs2, rs1, f3, rd, OP_REG};
    endfunction

    function automatic logic [31:0] enc_i(logic [6:0] op, logic [2:0] f3, logic [4:0] rd,
                                          logic [4:0] rs1, logic [11:0] imm);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                          logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                          logic [12:0] o);
        return {o[12], o[10:5], rs2, rs1, f3, o[4:1], o[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(logic [4:0] rd, logic [20:0] o);
        return {o[20], o[10:1], o[11], o[19:12], rd, OP_JAL};
    endfunction

    // ---------------- transfer driver ----------------
    task automatic send_item(logic [1:0] fn, logic [31:0] ins, logic [15:0] addr,
                             logic [31:0] data);
        @(negedge aclk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {data, addr, ins};
        do @(posedge aclk); while (!s_axis_tready);
        pending_results.push_back(predict_item(fn, ins, addr, data));
        items_sent++;
    endtask

    task automatic exec(logic [31:0] ins);
        send_item(FUNC_EXEC, ins, 16'($urandom), $urandom);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
    endtask

    // ---------------- random generators ----------------
    task automatic rand_load();
        logic [2:0]  f3;
        logic [4:0]  rs1;
        logic [11:0] imm;
        logic [15:0] e;
        int          start;
        f3 = 3'($urandom_range(0, 2));
        rs1 = 5'($urandom);
        imm = 12'($urandom);
        if (!mem_known(gpr[rs1] + {{20{imm[11]}}, imm}, 1 << f3)) begin
            // fall back to an x0-relative word that is known to be written
            rs1 = REG_ZERO;
            start = $urandom_range(0, word_addrs.size() - 1);
            for (int i = 0; i < word_addrs.size(); i++) begin
                e = word_addrs[(start + i) % word_addrs.size()];
                if (e < 16'd2048 || e >= 16'd63488) begin
                    imm = e[11:0];
                    break;
                end
            end
        end
        exec(enc_i(OP_LOAD, f3, 5'($urandom), rs1, imm));
    endtask

    task automatic rand_op();
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [11:0] imm;
        logic [31:0] w;
        rd  = 5'($urandom);
        rs1 = 5'($urandom);
        rs2 = 5'($urandom);
        imm = 12'($urandom);
        case ($urandom_range(0, 19))
            0, 1, 2, 3: begin
                case ($urandom_range(0, 12))
                    0: begin f7 = F7_BASE;   f3 = F3_ADD;  end
                    1: begin f7 = F7_ALT;    f3 = F3_ADD;  end
                    2: begin f7 = F7_BASE;   f3 = F3_SLL;  end
                    3: begin f7 = F7_BASE;   f3 = F3_SLT;  end
                    4: begin f7 = F7_BASE;   f3 = F3_XOR;  end
                    5: begin f7 = F7_BASE;   f3 = F3_SR;   end
                    6: begin f7 = F7_ALT;    f3 = F3_SR;   end
                    7: begin f7 = F7_BASE;   f3 = F3_OR;   end
                    8: begin f7 = F7_BASE;   f3 = F3_AND;  end
                    9: begin f7 = F7_MULDIV; f3 = F3_MUL;  end
                    10: begin f7 = F7_MULDIV; f3 = F3_MULH; end
                    11: begin f7 = F7_MULDIV; f3 = F3_DIV;  end
                    default: begin f7 = F7_MULDIV; f3 = F3_REM; end
                endcase
                exec(enc_r(f7, f3, rd, rs1, rs2));
            end
            4, 5, 6: begin
                f3 = 3'($urandom);
                if (f3 == F3_SLL)
                    imm[11:5] = F7_BASE;
                else if (f3 == F3_SR)
                    imm[11:5] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
                exec(enc_i(OP_IMM, f3, rd, rs1, imm));
            end
            7: exec({20'($urandom), rd, OP_LUI});
            8: exec({20'($urandom), rd, OP_AUIPC});
            9: begin
                exec({20'($urandom), rd, OP_LUI});
                exec(enc_i(OP_IMM, F3_ADD, rd, rd, imm));
            end
            10, 11: rand_load();
            12, 13: begin
                if ($urandom_range(0, 1)) rs1 = REG_ZERO;
                exec(enc_s(3'($urandom_range(0, 2)), rs1, rs2, imm));
            end
            14: exec(enc_b($urandom_range(0, 1) ? F3_BEQ : F3_BNE, rs1, rs2, 13'($urandom)));
            15: exec(enc_j(rd, 21'($urandom)));
            16: begin
                case ($urandom_range(0, 2))
                    0: w = SYS_PRINT_INT;
                    1: w = SYS_PRINT_STR;
                    default: w = SYS_PRINT_CHAR;
                endcase
                exec(enc_i(OP_IMM, F3_ADD, REG_A0, REG_ZERO, w[11:0]));
                if ($urandom_range(0, 1))
                    exec(enc_r(F7_BASE, F3_XOR, REG_A1, rs1, rs2));
                exec(ECALL_WORD);
            end
            17: begin
                // expose a register through memory
                exec(enc_s(F3_WORD, REG_ZERO, rs2, imm & 12'h7FF));
                send_item(FUNC_READ, $urandom, {5'd0, imm[10:0]}, $urandom);
            end
            18: send_item(FUNC_WRITE, $urandom, 16'($urandom), $urandom);
            default: begin
                if ($urandom_range(0, 3) == 0)
                    send_item(FUNC_NONE, $urandom, 16'($urandom), $urandom);
                else
                    send_item(FUNC_READ, $urandom,
                              word_addrs[$urandom_range(0, word_addrs.size() - 1)], $urandom);
            end
        endcase
    endtask

    // ---------------- tests ----------------
    task automatic test_memory_items();
        send_item(FUNC_WRITE, '0, 16'h0010, 32'h8081_7F01);
        send_item(FUNC_WRITE, '0, 16'hFFFE, 32'hFFFF_0000);
        send_item(FUNC_READ, '0, 16'h0010, '0);
        send_item(FUNC_READ, '0, 16'hFFFE, '0);
        send_item(FUNC_NONE, '1, 16'hFFFF, '1);
    endtask

    task automatic test_arith_corners();
        exec({20'h80000, 5'd1, OP_LUI});
        exec(enc_i(OP_IMM, F3_ADD, 5'd2, REG_ZERO, 12'hFFF));
        exec(enc_r(F7_MULDIV, F3_DIV, 5'd3, 5'd1, 5'd2));
        exec(enc_r(F7_MULDIV, F3_REM, 5'd4, 5'd1, 5'd2));
        exec(enc_r(F7_MULDIV, F3_DIV, 5'd5, 5'd1, REG_ZERO));
        exec(enc_r(F7_MULDIV, F3_REM, 5'd6, 5'd1, REG_ZERO));
        exec(enc_r(F7_MULDIV, F3_MULH, 5'd7, 5'd1, 5'd1));
        exec(enc_i(OP_IMM, F3_SR, 5'd8, 5'd1, {F7_ALT, 5'd31}));
        exec(enc_i(OP_IMM, F3_SLTU, 5'd9, 5'd2, 12'h001));
        exec(enc_i(OP_IMM, F3_ADD, REG_ZERO, REG_ZERO, 12'h7FF));
        exec(enc_i(OP_LOAD, F3_BYTE, 5'd12, REG_ZERO, 12'h011));
        exec(enc_i(OP_LOAD, F3_HALF, 5'd13, REG_ZERO, 12'h012));
        exec(enc_i(OP_LOAD, F3_WORD, 5'd14, REG_ZERO, 12'hFFE));
        exec(enc_s(F3_WORD, REG_ZERO, 5'd3, 12'h100));
        exec(enc_s(F3_BYTE, REG_ZERO, 5'd7, 12'h101));
        send_item(FUNC_READ, '0, 16'h0100, '0);
    endtask

    task automatic test_ecall_prints();
        exec(enc_r(F7_BASE, F3_OR, REG_A1, 5'd6, REG_ZERO));
        exec(enc_i(OP_IMM, F3_ADD, REG_A0, REG_ZERO, SYS_PRINT_CHAR[11:0]));
        exec(ECALL_WORD);
        exec(enc_b(F3_BNE, REG_A0, REG_ZERO, 13'h1FF8));
        exec(enc_j(5'd1, 21'h0FFFFE));
    endtask

    task automatic test_random_mix(int n);
        while (items_sent < n) begin
            if (items_sent >= 400 && items_sent < 405 && hold_req == 0)
                hold_req = 300;
            if (items_sent >= 600 && items_sent < 605)
                wait_drained();
            if (items_sent >= n - 100)
                calm = 1'b1;
            rand_op();
        end
    endtask

    task automatic test_halt();
        case ($urandom_range(0, 3))
            0: begin
                halt_kind = "illegal opcode";
                exec({25'($urandom), OP_UNUSED});
            end
            1: begin
                halt_kind = "bad shift immediate";
                exec(enc_i(OP_IMM, F3_SLL, 5'd3, 5'd1, {F7_ALT, 5'($urandom)}));
            end
            2: begin
                halt_kind = "exit call";
                exec(enc_i(OP_IMM, F3_ADD, REG_A0, REG_ZERO, SYS_EXIT[11:0]));
                exec(ECALL_WORD);
            end
            default: begin
                halt_kind = "unknown call";
                exec(enc_i(OP_IMM, F3_ADD, REG_A0, REG_ZERO, 12'($urandom_range(12, 2047))));
                exec(ECALL_WORD);
            end
        endcase
        exec({20'h12345, 5'd1, OP_LUI});
        exec(ECALL_WORD);
        send_item(FUNC_WRITE, '0, 16'h0200, 32'hDEAD_BEEF);
        send_item(FUNC_READ, '0, 16'h0200, '0);
    endtask

    // ---------------- result checker ----------------
    always @(posedge aclk) begin
        exec_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with no transfer outstanding: %h", m_axis_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[2:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tdata[2:0]);
                    errors++;
                end
                if (m_axis_tdata[34:3] !== want.pc) begin
                    $error("pc: expected %h, got %h", want.pc, m_axis_tdata[34:3]);
                    errors++;
                end
                if (m_axis_tdata[66:35] !== want.value) begin
                    $error("value: expected %h, got %h", want.value, m_axis_tdata[66:35]);
                    errors++;
                end
            end
        end
    end

    // receiver: random stall bursts, plus long hold-offs on request
    initial begin
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req > 0) begin
                hold_req--;
                m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(0, 17);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        #4ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        hold_req = 0;
        calm = 1'b0;
        halt_kind = "";
        foreach (gpr[i]) gpr[i] = '0;
        arch_pc = '0;
        arch_halted = 1'b0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = FUNC_EXEC;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_memory_items();
        test_arith_corners();
        test_ecall_prints();
        test_random_mix(880);
        test_halt();
        wait_drained();
        repeat (60) @(posedge aclk);

        $display("Ran %0d transfers, %0d results checked, over ALU, M-extension, load/store,",
                 items_sent, results_seen);
        $display("branch, jump, ecall and memory items; core halted by %s.", halt_kind);
        if (errors == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
src/rv32_pkg.sv
src/rv32_ram.sv
src/rv32_alu.sv
src/rv32im_subset_execute.sv
tb/sv/rv32im_subset_execute_tb.sv
